FILE: rtl/asd_pkg.sv
// Shared types, constants and sequencer states of the accelerometer step detector.
`timescale 1ns / 1ps

package asd_pkg;

  // Stream and register port widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 40;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Datapath widths
  localparam int ACCEL_W = 16;
  localparam int TS_W    = 32;
  localparam int CFG_W   = 16;
  localparam int MAG_W   = 32;
  localparam int OPA_W   = 32;
  localparam int OPB_W   = 20;
  localparam int ACC_W   = OPA_W + OPB_W;
  localparam int HIK_W   = 19;
  localparam int LOK_W   = 17;
  localparam int RATIO_W = 17;

  // Q16 coefficients
  localparam logic [OPB_W-1:0] K_FILT_OLD  = 20'd19661;
  localparam logic [OPB_W-1:0] K_FILT_NEW  = 20'd45875;
  localparam logic [OPB_W-1:0] K_BASE_OLD  = 20'd65470;
  localparam logic [OPB_W-1:0] K_BASE_NEW  = 20'd66;
  localparam logic [OPB_W-1:0] K_HIGH_GAIN = 20'd72090;
  localparam logic [OPB_W-1:0] K_UNITY     = 20'd65536;
  localparam logic [RATIO_W-1:0] Q16_ONE   = 17'd65536;
  localparam logic [ACC_W-1:0] ROUND_HALF  = 52'd32768;
  localparam logic [MAG_W-1:0] ONE_G_SQ    = 32'd4194304;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_THRESHOLD_FRAC = 16'd655;
  localparam logic [CFG_W-1:0] RST_MIN_STEP_GAP   = 16'd200;
  localparam logic [CFG_W-1:0] RST_MIN_HIGH_WIDTH = 16'd10;
  localparam logic [CFG_W-1:0] RST_MAX_HIGH_WIDTH = 16'd1500;

  // Register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD_FRAC = 2'd0,
    REG_MIN_STEP_GAP   = 2'd1,
    REG_MIN_HIGH_WIDTH = 2'd2,
    REG_MAX_HIGH_WIDTH = 2'd3
  } reg_idx_t;

  // Opcodes on the input tuser
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Accumulator start value for one multiply step
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_ROUND
  } mac_base_t;

  typedef struct packed {
    logic             en;
    mac_base_t        base;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAG_X,
    ST_MAG_Y,
    ST_MAG_Z,
    ST_FILT_OLD,
    ST_FILT_NEW,
    ST_BASE_OLD,
    ST_BASE_NEW,
    ST_UP_SQ,
    ST_HI_GAIN,
    ST_DN_SQ,
    ST_HI_MUL,
    ST_LO_MUL,
    ST_DECIDE
  } state_t;

endpackage

FILE: rtl/asd_mac.sv
// Shared multiply-accumulate unit with a registered accumulator.
`timescale 1ns / 1ps

module asd_mac import asd_pkg::*; (
  input  logic             clk,
  input  mac_cmd_t         cmd,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] product;
  logic [ACC_W-1:0] base;

  assign product = {{(ACC_W-OPA_W){1'b0}}, cmd.a} * {{(ACC_W-OPB_W){1'b0}}, cmd.b};

  always_comb begin
    unique case (cmd.base)
      BASE_ZERO:  base = '0;
      BASE_ACC:   base = acc;
      BASE_ROUND: base = ROUND_HALF;
      default:    base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      acc <= base + product;
    end
  end

endmodule

FILE: rtl/accel_step_detector.sv
// Top level of the accelerometer step detector: register port, sequencer and gates.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one request per sample. s_tuser selects the operation:
//   process a sample, or clear the step count, last-step time and phase.
//   Output stream (m_*): exactly one result per request: step count, step
//   found, step rejected and current phase.
//   Register port (APB style): threshold fraction, minimum step gap, minimum
//   and maximum high width at byte addresses 0, 4, 8, 12. Write only while idle.
// Timing
//   A process request, once accepted, steps through the sequencer: every multiply goes
//   through the single 32x20 multiply-accumulate unit, 12 products in turn,
//   then one decision state. A clear request passes through its clear state.
//   The result register is loaded in the last cycle and shows on m_tvalid in
//   the next; s_tready returns at the same time, so a new request can enter
//   while the result still waits. s_tready stays low from acceptance until then.
// Reset
//   rst clears the registers to their defaults, the filters to empty and the
//   baseline to 1 g squared, drops m_tvalid and returns the sequencer to idle.
// Stall
//   If m_tready stays low, the result is held and the next request finishes
//   its arithmetic, then waits in its last cycle until the result slot frees.

module accel_step_detector import asd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // accel_x, accel_y, accel_z, timestamp
  input  logic [0:0]           s_tuser,  // opcode
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // step_count, step_found, step_rejected, phase, pad
);

  // Configuration registers
  logic [CFG_W-1:0] threshold_frac;
  logic [CFG_W-1:0] min_step_gap;
  logic [CFG_W-1:0] min_high_width;
  logic [CFG_W-1:0] max_high_width;
  logic             cfg_write;
  reg_idx_t         cfg_idx;

  // Sequencer
  state_t   state;
  state_t   state_next;
  mac_cmd_t cmd;
  logic [ACC_W-1:0] acc;
  logic     out_free;
  logic     commit_sample;
  logic     commit_clear;

  // Captured sample
  logic [ACCEL_W-1:0] accel_x;
  logic [ACCEL_W-1:0] accel_y;
  logic [ACCEL_W-1:0] accel_z;
  logic [ACCEL_W-1:0] ax_mag;
  logic [ACCEL_W-1:0] ay_mag;
  logic [ACCEL_W-1:0] az_mag;
  logic [TS_W-1:0]    sample_ts;

  // Filter and detector state
  logic [MAG_W-1:0] smoothed_mag;
  logic [MAG_W-1:0] baseline_mag;
  logic [MAG_W-1:0] mag_hold;
  logic [HIK_W-1:0] hi_k;
  logic [LOK_W-1:0] lo_k;
  logic             above;
  logic             high_phase;
  logic [TS_W-1:0]  high_start;
  logic [TS_W-1:0]  last_step;
  logic [TS_W-1:0]  steps;
  logic             smooth_empty;
  logic [RATIO_W-1:0] up_ratio;
  logic [RATIO_W-1:0] dn_ratio;

  // Decision
  logic [ACC_W-1:0] lhs;
  logic             below;
  logic             phase_next;
  logic             rise;
  logic             fall;
  logic [TS_W-1:0]  phase_span;
  logic [TS_W-1:0]  step_gap;
  logic             gates_ok;
  logic             step_ok;

  // Result register
  logic [TS_W-1:0] out_count;
  logic            out_found;
  logic            out_rejected;
  logic            out_phase;

  // ---------------------------------------------------------------- register port
  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    unique case (cfg_idx)
      REG_THRESHOLD_FRAC: prdata = {{(PDATA_W-CFG_W){1'b0}}, threshold_frac};
      REG_MIN_STEP_GAP:   prdata = {{(PDATA_W-CFG_W){1'b0}}, min_step_gap};
      REG_MIN_HIGH_WIDTH: prdata = {{(PDATA_W-CFG_W){1'b0}}, min_high_width};
      REG_MAX_HIGH_WIDTH: prdata = {{(PDATA_W-CFG_W){1'b0}}, max_high_width};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_frac <= RST_THRESHOLD_FRAC;
      min_step_gap   <= RST_MIN_STEP_GAP;
      min_high_width <= RST_MIN_HIGH_WIDTH;
      max_high_width <= RST_MAX_HIGH_WIDTH;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_THRESHOLD_FRAC: threshold_frac <= pwdata[CFG_W-1:0];
        REG_MIN_STEP_GAP:   min_step_gap   <= pwdata[CFG_W-1:0];
        REG_MIN_HIGH_WIDTH: min_high_width <= pwdata[CFG_W-1:0];
        REG_MAX_HIGH_WIDTH: max_high_width <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- request unpack
  assign accel_x = s_tdata[15:0];
  assign accel_y = s_tdata[31:16];
  assign accel_z = s_tdata[47:32];

  // Squares only need magnitudes; the most negative code maps to 2^15.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ax_mag    <= accel_x[ACCEL_W-1] ? ACCEL_W'(-accel_x) : accel_x;
      ay_mag    <= accel_y[ACCEL_W-1] ? ACCEL_W'(-accel_y) : accel_y;
      az_mag    <= accel_z[ACCEL_W-1] ? ACCEL_W'(-accel_z) : accel_z;
      sample_ts <= s_tdata[79:48];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign s_tready     = (state == ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  assign smooth_empty = (smoothed_mag == '0);
  assign up_ratio     = {1'b1, threshold_frac};
  assign dn_ratio     = Q16_ONE - {1'b0, threshold_frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.en        = 1'b0;
    cmd.base      = BASE_ZERO;
    cmd.a         = '0;
    cmd.b         = '0;
    commit_sample = 1'b0;
    commit_clear  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == OP_CLEAR) ? ST_CLEAR : ST_MAG_X;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          commit_clear = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      // sum of squares
      ST_MAG_X: begin
        cmd.en = 1'b1; cmd.base = BASE_ZERO;
        cmd.a = OPA_W'(ax_mag); cmd.b = OPB_W'(ax_mag);
        state_next = ST_MAG_Y;
      end
      ST_MAG_Y: begin
        cmd.en = 1'b1; cmd.base = BASE_ACC;
        cmd.a = OPA_W'(ay_mag); cmd.b = OPB_W'(ay_mag);
        state_next = ST_MAG_Z;
      end
      ST_MAG_Z: begin
        cmd.en = 1'b1; cmd.base = BASE_ACC;
        cmd.a = OPA_W'(az_mag); cmd.b = OPB_W'(az_mag);
        state_next = ST_FILT_OLD;
      end
      // smoothing filter; an empty filter loads the magnitude at unity gain
      ST_FILT_OLD: begin
        cmd.en = 1'b1; cmd.base = BASE_ROUND;
        cmd.a = smooth_empty ? acc[MAG_W-1:0] : smoothed_mag;
        cmd.b = smooth_empty ? K_UNITY : K_FILT_OLD;
        state_next = ST_FILT_NEW;
      end
      ST_FILT_NEW: begin
        cmd.en = 1'b1; cmd.base = BASE_ACC;
        cmd.a = mag_hold;
        cmd.b = smooth_empty ? '0 : K_FILT_NEW;
        state_next = ST_BASE_OLD;
      end
      // gravity baseline
      ST_BASE_OLD: begin
        cmd.en = 1'b1; cmd.base = BASE_ROUND;
        cmd.a = baseline_mag; cmd.b = K_BASE_OLD;
        state_next = ST_BASE_NEW;
      end
      ST_BASE_NEW: begin
        cmd.en = 1'b1; cmd.base = BASE_ACC;
        cmd.a = smoothed_mag; cmd.b = K_BASE_NEW;
        state_next = ST_UP_SQ;
      end
      // threshold factors
      ST_UP_SQ: begin
        cmd.en = 1'b1; cmd.base = BASE_ROUND;
        cmd.a = OPA_W'(up_ratio); cmd.b = OPB_W'(up_ratio);
        state_next = ST_HI_GAIN;
      end
      ST_HI_GAIN: begin
        cmd.en = 1'b1; cmd.base = BASE_ROUND;
        cmd.a = OPA_W'(acc[34:16]); cmd.b = K_HIGH_GAIN;
        state_next = ST_DN_SQ;
      end
      ST_DN_SQ: begin
        cmd.en = 1'b1; cmd.base = BASE_ROUND;
        cmd.a = OPA_W'(dn_ratio); cmd.b = OPB_W'(dn_ratio);
        state_next = ST_HI_MUL;
      end
      // threshold products against the baseline
      ST_HI_MUL: begin
        cmd.en = 1'b1; cmd.base = BASE_ZERO;
        cmd.a = baseline_mag; cmd.b = OPB_W'(hi_k);
        state_next = ST_LO_MUL;
      end
      ST_LO_MUL: begin
        cmd.en = 1'b1; cmd.base = BASE_ZERO;
        cmd.a = baseline_mag; cmd.b = OPB_W'(lo_k);
        state_next = ST_DECIDE;
      end
      // hold here until the result slot is free
      ST_DECIDE: begin
        if (out_free) begin
          commit_sample = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  asd_mac u_mac (
    .clk (clk),
    .cmd (cmd),
    .acc (acc)
  );

  // ---------------------------------------------------------------- decision
  assign lhs        = ACC_W'({smoothed_mag, 16'b0});
  assign below      = lhs < acc;
  assign phase_next = above | (!below & high_phase);
  assign rise       = !high_phase & phase_next;
  assign fall       = high_phase & !phase_next;
  assign phase_span = sample_ts - high_start;
  assign step_gap   = sample_ts - last_step;
  assign gates_ok   = (step_gap > TS_W'(min_step_gap)) &&
                      (phase_span >= TS_W'(min_high_width)) &&
                      (phase_span <= TS_W'(max_high_width));
  assign step_ok    = fall & gates_ok;

  // ---------------------------------------------------------------- state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_mag <= '0;
      baseline_mag <= ONE_G_SQ;
      high_phase   <= 1'b0;
      high_start   <= '0;
      last_step    <= '0;
      steps        <= '0;
    end else begin
      if (state == ST_BASE_OLD) begin
        smoothed_mag <= acc[47:16];
      end
      if (state == ST_UP_SQ) begin
        baseline_mag <= acc[47:16];
      end
      if (commit_clear) begin
        high_phase <= 1'b0;
        last_step  <= '0;
        steps      <= '0;
      end else if (commit_sample) begin
        high_phase <= phase_next;
        if (rise) begin
          high_start <= sample_ts;
        end
        if (step_ok) begin
          steps     <= steps + TS_W'(1);
          last_step <= sample_ts;
        end
      end
    end
  end

  // Intermediate products of the running request
  always_ff @(posedge clk) begin
    if (state == ST_FILT_OLD) begin
      mag_hold <= acc[MAG_W-1:0];
    end
    if (state == ST_DN_SQ) begin
      hi_k <= acc[34:16];
    end
    if (state == ST_HI_MUL) begin
      lo_k <= acc[32:16];
    end
    if (state == ST_LO_MUL) begin
      above <= lhs > acc;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit_sample || commit_clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_clear) begin
      out_count    <= '0;
      out_found    <= 1'b0;
      out_rejected <= 1'b0;
      out_phase    <= 1'b0;
    end else if (commit_sample) begin
      out_count    <= step_ok ? steps + TS_W'(1) : steps;
      out_found    <= step_ok;
      out_rejected <= fall & !gates_ok;
      out_phase    <= phase_next;
    end
  end

  assign m_tdata = {5'b0, out_phase, out_rejected, out_found, out_count};

  // ---------------------------------------------------------------- assertions
  a_found_xor_rejected: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
    else $error("step found and rejected in one result");

  a_steps_advance_by_one: assert property (@(posedge clk) disable iff (rst)
    !$stable(steps) |-> ((steps == ($past(steps) + 32'd1)) || (steps == 32'd0)))
    else $error("step count jumped");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DECIDE || $past(state) == ST_CLEAR))
    else $error("result raised outside a commit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after an accepted request");

endmodule

FILE: bench/tb_accel_step_detector.sv
// Self-checking testbench for the accelerometer step detector.
`timescale 1ns / 1ps

module tb_accel_step_detector import asd_pkg::*; ();

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 24;   // long enough for a process request to finish end to end
  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off to back up the input
  localparam int HOLD_AFTER    = 300;  // results checked before that hold-off
  localparam int REPORT_LIMIT  = 10;

  // One expected result: the step counter, the two fall flags and the phase.
  typedef struct {
    logic [31:0] count;
    logic        found;
    logic        rejected;
    logic        phase;
  } step_report_t;

  // Tracks the detector state and the register settings, and checks every result
  // against the oldest report still due.
  class pedometer_scoreboard;
    logic [CFG_W-1:0] frac, gap_min, width_min, width_max;
    logic [63:0]      smooth, base;
    logic             high;
    logic [31:0]      high_start, last_step, steps;
    step_report_t     due_reports[$];
    int               mismatches;
    int               checked;

    function new();
      frac       = RST_THRESHOLD_FRAC;
      gap_min    = RST_MIN_STEP_GAP;
      width_min  = RST_MIN_HIGH_WIDTH;
      width_max  = RST_MAX_HIGH_WIDTH;
      smooth     = '0;
      base       = 64'(ONE_G_SQ);
      high       = 1'b0;
      high_start = '0;
      last_step  = '0;
      steps      = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_THRESHOLD_FRAC: frac      = value;
        REG_MIN_STEP_GAP:   gap_min   = value;
        REG_MIN_HIGH_WIDTH: width_min = value;
        REG_MAX_HIGH_WIDTH: width_max = value;
        default: ;
      endcase
    endfunction

    // Q16 weighted sum, rounded half up.
    function logic [63:0] blend_q16(logic [63:0] wa, logic [63:0] xa,
                                    logic [63:0] wb, logic [63:0] xb);
      return (wa * xa + wb * xb + 64'd32768) >> 16;
    endfunction

    // Advance the detector state by one accepted request and queue its report.
    function void note_sample(logic op, logic [S_TDATA_W-1:0] d);
      step_report_t rep;
      shortint      ax, ay, az;
      logic [31:0]  ts, width, gap;
      logic [63:0]  mag, up, dn, hi_k, lo_k, lhs;
      logic         next_high;
      rep.found    = 1'b0;
      rep.rejected = 1'b0;
      if (op == OP_CLEAR) begin
        // filters and high_start survive a clear
        steps     = '0;
        last_step = '0;
        high      = 1'b0;
      end else begin
        ax  = shortint'(d[15:0]);
        ay  = shortint'(d[31:16]);
        az  = shortint'(d[47:32]);
        ts  = d[79:48];
        mag = 64'(longint'(ax) * longint'(ax)) + 64'(longint'(ay) * longint'(ay)) +
              64'(longint'(az) * longint'(az));
        // an empty filter loads the magnitude as it is
        if (smooth == 0)
          smooth = mag;
        else
          smooth = blend_q16(64'(K_FILT_OLD), smooth, 64'(K_FILT_NEW), mag);
        base = blend_q16(64'(K_BASE_OLD), base, 64'(K_BASE_NEW), smooth);

        up   = 64'(Q16_ONE) + 64'(frac);
        dn   = 64'(Q16_ONE) - 64'(frac);
        hi_k = (up * up + 64'd32768) >> 16;
        hi_k = (64'(K_HIGH_GAIN) * hi_k + 64'd32768) >> 16;
        lo_k = (dn * dn + 64'd32768) >> 16;

        // exact comparison, no rounding on either side
        lhs = smooth << 16;
        if (lhs > hi_k * base)
          next_high = 1'b1;
        else if (lhs < lo_k * base)
          next_high = 1'b0;
        else
          next_high = high;

        if (!high && next_high)
          high_start = ts;

        if (high && !next_high) begin
          width = ts - high_start;
          gap   = ts - last_step;
          if (gap > 32'(gap_min) && width >= 32'(width_min) && width <= 32'(width_max)) begin
            steps     = steps + 1;
            last_step = ts;
            rep.found = 1'b1;
          end else begin
            rep.rejected = 1'b1;
          end
        end
        high = next_high;
      end
      rep.count = steps;
      rep.phase = high;
      due_reports.push_back(rep);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d);
      step_report_t want;
      checked++;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with nothing due: count %0d found %0b rejected %0b phase %0b",
                   d[31:0], d[32], d[33], d[34]);
      end else begin
        want = due_reports.pop_front();
        if (d[31:0] !== want.count || d[32] !== want.found ||
            d[33] !== want.rejected || d[34] !== want.phase) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch count/found/rejected/phase: want %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                     want.count, want.found, want.rejected, want.phase,
                     d[31:0], d[32], d[33], d[34]);
        end
      end
    endfunction

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // accel_x, accel_y, accel_z, timestamp
  logic [0:0]           s_tuser = '0;  // opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // step_count, step_found, step_rejected, phase, pad

  pedometer_scoreboard sb = new();

  logic        steady_flow = 1'b0;  // when set, neither side idles
  logic [31:0] now_ms = '0;         // running sample clock for the walking stimulus

  always #HALF_PERIOD clk = ~clk;

  accel_step_detector u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Watch both streams. Check the result before noting a new request so that a
  // result can never match the request accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
      if (s_tvalid && s_tready)
        sb.note_sample(s_tuser[0], s_tdata);
    end
  end

  // Result side: stall a random number of cycles before each result, and once hold
  // off for a long stretch so the block backs up and drops s_tready.
  initial begin : result_sink
    int  stall;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(logic op, logic [15:0] ax, logic [15:0] ay,
                              logic [15:0] az, logic [31:0] ts);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser[0] <= op;
    s_tdata    <= {ts, az, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready. The caller
  // releases the bus after its last write.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Drain every result, let the block go quiet, then load a new register set.
  task automatic load_settings(logic [CFG_W-1:0] frac, logic [CFG_W-1:0] gap_min,
                               logic [CFG_W-1:0] width_min, logic [CFG_W-1:0] width_max);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_THRESHOLD_FRAC, frac);
    write_reg(REG_MIN_STEP_GAP, gap_min);
    write_reg(REG_MIN_HIGH_WIDTH, width_min);
    write_reg(REG_MAX_HIGH_WIDTH, width_max);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic real pick_real(real lo, real hi);
    return lo + (hi - lo) * real'($urandom_range(0, 1000)) / 1000.0;
  endfunction

  // Send a sample of about the given squared magnitude in units of the current
  // baseline: spread it over the axes, lead axis random, signs random, small jitter.
  task automatic send_level(real ratio);
    real amp, part;
    int  axis_val[3];
    int  k, lead, v;
    amp  = $sqrt(ratio * real'(sb.base)) ;
    lead = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      part = (amp > 32767.0) ? 32767.0 : amp;
      amp  = (amp * amp > part * part) ? $sqrt(amp * amp - part * part) : 0.0;
      v = int'(part);
      if ($urandom_range(0, 1)) v = -v;
      v = v + int'($urandom_range(0, 63)) - 32;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      axis_val[(lead + k) % 3] = v;
    end
    now_ms = now_ms + $urandom_range(3, 60);
    send_request(OP_PROCESS, 16'(axis_val[0]), 16'(axis_val[1]), 16'(axis_val[2]), now_ms);
  endtask

  // Mostly walking strides (rest, impact, release) with random content; the rest is
  // noise: full-range samples, lone spikes or dips, clock jumps and clears.
  task automatic run_walk(int n_items);
    int sent, pick, k, n_rest, n_hi, n_lo;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_request(OP_PROCESS, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        sent++;
      end else if (pick < 5) begin
        send_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        sent++;
      end else if (pick < 10) begin
        if (pick < 7) now_ms = now_ms + $urandom_range(0, 4000);
        send_level(pick_real(0.05, 3.0));
        sent++;
      end else begin
        n_rest = $urandom_range(0, 4);
        n_hi   = $urandom_range(1, 6);
        n_lo   = (pick < 15) ? 0 : $urandom_range(1, 8);  // some strides never release
        for (k = 0; k < n_rest; k++) send_level(pick_real(0.95, 1.05));
        for (k = 0; k < n_hi; k++)   send_level(pick_real(1.5, 3.0));
        for (k = 0; k < n_lo; k++)   send_level(pick_real(0.1, 0.85));
        sent += n_rest + n_hi + n_lo;
      end
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty filter, filter returning to zero, accepted step, fall too
    // soon after a step, high phase across the clock wrap, clears and extremes.
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd0, 32'd0);
    send_request(OP_PROCESS, 16'd1, 16'd0, 16'd0, 32'd1);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd0, 32'd2);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd2048, 32'd10);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd2048, 32'd20);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd3072, 32'd250);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd3072, 32'd270);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd1024, 32'd300);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd3072, 32'd320);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd1024, 32'd340);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd3072, 32'hFFFF_FFF0);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd1024, 32'h0000_0020);
    send_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_PROCESS, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
    send_request(OP_PROCESS, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000);
    send_request(OP_PROCESS, 16'h8000, 16'd0, 16'd0, 32'h8000_0010);
    send_request(OP_PROCESS, 16'd0, 16'h8000, 16'd0, 32'h8000_0020);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'h7FFF, 32'h8000_0030);
    send_request(OP_CLEAR, 16'd0, 16'd0, 16'd0, 32'd0);          // clear while high
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd0, 32'h8000_0040);
    send_request(OP_PROCESS, 16'd0, 16'd0, 16'd0, 32'h8000_0050);
    now_ms = 32'h8000_0100;

    // Defaults, with the long hold-off somewhere in here.
    run_walk(400);

    // Widest gates, smallest fraction, no idling on either side.
    load_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
    steady_flow = 1'b1;
    run_walk(300);
    steady_flow = 1'b0;

    // Largest fraction and crossed width bounds: every fall is rejected.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    run_walk(250);

    // Tight gates with the sample clock about to wrap.
    load_settings(16'd3000, 16'd150, 16'd20, 16'd400);
    now_ms = 32'hFFFF_F800;
    run_walk(400);

    load_settings(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 400)),
                  16'($urandom_range(0, 50)), 16'($urandom_range(100, 2000)));
    run_walk(300);

    load_settings(RST_THRESHOLD_FRAC, RST_MIN_STEP_GAP, RST_MIN_HIGH_WIDTH,
                  RST_MAX_HIGH_WIDTH);
    run_walk(350);

    // Wait out every report still due, then a little longer for stray results.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("accel_step_detector regression: pass");
    else
      $display("accel_step_detector regression: fail");
    $finish;
  end

  // Watchdog, many times the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("accel_step_detector regression: fail");
    $finish;
  end

endmodule
